// File: hw/rtl/taae_pkg.sv
`default_nettype none
package taae_pkg;
	localparam logic [3:0] SP_IDX = 4'd13;

	typedef enum logic [1:0] {
		CMD_EXEC  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_READ  = 2'd2,
		CMD_ALT   = 2'd3
	} cmd_t;

	localparam logic [4:0] ENC_ADC_REG_T1 = 5'd0;
	localparam logic [4:0] ENC_ADD_IMM_T1 = 5'd1;
	localparam logic [4:0] ENC_ADD_IMM_T2 = 5'd2;
	localparam logic [4:0] ENC_ADD_REG_T1 = 5'd3;
	localparam logic [4:0] ENC_ADD_REG_T2 = 5'd4;
	localparam logic [4:0] ENC_ADD_SPI_T1 = 5'd5;
	localparam logic [4:0] ENC_ADD_SPI_T2 = 5'd6;
	localparam logic [4:0] ENC_ADD_SPR_T1 = 5'd7;
	localparam logic [4:0] ENC_ADD_SPR_T2 = 5'd8;
	localparam logic [4:0] ENC_ADC_IMM_T1 = 5'd9;
	localparam logic [4:0] ENC_ADC_REG_T2 = 5'd10;
	localparam logic [4:0] ENC_ADD_IMM_T3 = 5'd11;
	localparam logic [4:0] ENC_ADD_IMM_T4 = 5'd12;
	localparam logic [4:0] ENC_ADD_REG_T3 = 5'd13;
	localparam logic [4:0] ENC_ADD_SPI_T3 = 5'd14;
	localparam logic [4:0] ENC_ADD_SPI_T4 = 5'd15;
	localparam logic [4:0] ENC_ADD_SPR_T3 = 5'd16;

	localparam logic [1:0] SH_LSL = 2'd0;
	localparam logic [1:0] SH_LSR = 2'd1;
	localparam logic [1:0] SH_ASR = 2'd2;
	localparam logic [1:0] SH_ROR = 2'd3;

	// Operand selection decoded from the instruction in the first stage.
	typedef struct packed {
		logic        valid;
		logic        exec;
		logic        wr;
		logic        rd;
		logic [3:0]  dest;
		logic [31:0] wval;
		logic [3:0]  a_idx;
		logic        b_reg;
		logic [3:0]  b_idx;
		logic [31:0] b_imm;
		logic        b_shift;
		logic [1:0]  sh_type;
		logic [4:0]  sh_amt;
		logic        use_c;
		logic        setf;
	} dec_t;
endpackage
`default_nettype wire

// File: hw/rtl/taae_decode.sv
`default_nettype none
module taae_decode (
	input  wire logic [1:0]  cmd,
	input  wire logic [4:0]  encoding,
	input  wire logic [15:0] instr_high,
	input  wire logic [15:0] instr_low,
	input  wire logic        in_it_block,
	input  wire logic [3:0]  reg_index,
	input  wire logic [31:0] write_value,
	output taae_pkg::dec_t   dec
);
	import taae_pkg::*;

	logic [11:0] imm12;
	logic [31:0] eimm;
	logic [7:0]  ib;
	logic [31:0] rot_src;
	logic [4:0]  rot;
	logic [3:0]  rd32, rn32, dn, m;
	logic        s32;

	assign s32   = instr_high[4];
	assign rn32  = instr_high[3:0];
	assign rd32  = instr_low[11:8];
	assign imm12 = {instr_high[10], instr_low[14:12], instr_low[7:0]};
	assign ib    = imm12[7:0];
	assign rot   = imm12[11:7];
	assign rot_src = {24'd0, 1'b1, imm12[6:0]};
	assign dn    = {instr_low[7], instr_low[2:0]};
	assign m     = instr_low[6:3];

	always_comb begin
		if (imm12[11:10] == 2'b00) begin
			case (imm12[9:8])
				2'd0: eimm = {24'd0, ib};
				2'd1: eimm = {8'd0, ib, 8'd0, ib};
				2'd2: eimm = {ib, 8'd0, ib, 8'd0};
				default: eimm = {ib, ib, ib, ib};
			endcase
		end else begin
			eimm = (rot_src >> rot) | (rot_src << (6'd32 - {1'b0, rot}));
		end
	end

	always_comb begin
		dec = '0;
		dec.valid = 1'b1;
		dec.wval = write_value;
		dec.dest = reg_index;
		dec.a_idx = rn32;
		dec.b_idx = instr_low[3:0];
		dec.sh_type = instr_low[5:4];
		dec.sh_amt = {instr_low[14:12], instr_low[7:6]};
		if (cmd == CMD_WRITE) begin
			dec.wr = 1'b1;
		end else if (cmd == CMD_EXEC && encoding <= ENC_ADD_SPR_T3) begin
			dec.exec = 1'b1;
			dec.wr = 1'b1;
			dec.dest = rd32;
			unique case (encoding)
				ENC_ADC_REG_T1: begin
					dec.dest = {1'b0, instr_low[2:0]}; dec.a_idx = dec.dest;
					dec.b_reg = 1'b1; dec.b_idx = {1'b0, instr_low[5:3]};
					dec.use_c = 1'b1; dec.setf = !in_it_block;
				end
				ENC_ADD_IMM_T1: begin
					dec.dest = {1'b0, instr_low[2:0]}; dec.a_idx = {1'b0, instr_low[5:3]};
					dec.b_imm = {29'd0, instr_low[8:6]}; dec.setf = !in_it_block;
				end
				ENC_ADD_IMM_T2: begin
					dec.dest = {1'b0, instr_low[10:8]}; dec.a_idx = dec.dest;
					dec.b_imm = {24'd0, instr_low[7:0]}; dec.setf = !in_it_block;
				end
				ENC_ADD_REG_T1: begin
					dec.dest = {1'b0, instr_low[2:0]}; dec.a_idx = {1'b0, instr_low[5:3]};
					dec.b_reg = 1'b1; dec.b_idx = {1'b0, instr_low[8:6]};
					dec.setf = !in_it_block;
				end
				ENC_ADD_REG_T2: begin
					// All three variants reduce to dn + m with SP taken from entry 13.
					dec.b_reg = 1'b1;
					if (m == SP_IDX) begin
						dec.dest = dn; dec.a_idx = SP_IDX; dec.b_idx = dn;
					end else if (dn == SP_IDX) begin
						dec.dest = SP_IDX; dec.a_idx = SP_IDX; dec.b_idx = m;
					end else begin
						dec.dest = dn; dec.a_idx = dn; dec.b_idx = m;
					end
				end
				ENC_ADD_SPI_T1: begin
					dec.dest = {1'b0, instr_low[10:8]}; dec.a_idx = SP_IDX;
					dec.b_imm = {22'd0, instr_low[7:0], 2'b00};
				end
				ENC_ADD_SPI_T2: begin
					dec.dest = SP_IDX; dec.a_idx = SP_IDX;
					dec.b_imm = {23'd0, instr_low[6:0], 2'b00};
				end
				ENC_ADD_SPR_T1: begin
					dec.dest = dn; dec.a_idx = SP_IDX; dec.b_reg = 1'b1; dec.b_idx = dn;
				end
				ENC_ADD_SPR_T2: begin
					dec.dest = SP_IDX; dec.a_idx = SP_IDX; dec.b_reg = 1'b1; dec.b_idx = m;
				end
				ENC_ADC_IMM_T1: begin
					dec.b_imm = eimm; dec.use_c = 1'b1; dec.setf = s32;
				end
				ENC_ADC_REG_T2: begin
					dec.b_reg = 1'b1; dec.b_shift = 1'b1; dec.use_c = 1'b1; dec.setf = s32;
				end
				ENC_ADD_IMM_T3: begin
					dec.b_imm = eimm; dec.setf = s32;
				end
				ENC_ADD_SPI_T3: begin
					dec.a_idx = SP_IDX; dec.b_imm = eimm; dec.setf = s32;
				end
				ENC_ADD_IMM_T4: dec.b_imm = {20'd0, imm12};
				ENC_ADD_SPI_T4: begin
					dec.a_idx = SP_IDX; dec.b_imm = {20'd0, imm12};
				end
				ENC_ADD_REG_T3: begin
					dec.b_reg = 1'b1; dec.b_shift = 1'b1; dec.setf = s32;
				end
				ENC_ADD_SPR_T3: begin
					dec.a_idx = SP_IDX; dec.b_reg = 1'b1; dec.b_shift = 1'b1;
					dec.setf = s32;
				end
				default: dec.exec = 1'b0;
			endcase
		end else if (cmd == CMD_EXEC) begin
			dec.dest = '0;
		end else begin
			// Read and alternate commands; the a port returns the value.
			dec.rd = 1'b1;
			dec.a_idx = reg_index;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/thumb_add_adc_execute_core.sv
`default_nettype none
// Two-stage execute unit: stage one decodes the request and reads both register
// operands from the synchronous register file at the accepting edge; stage two
// shifts, adds, writes the result back and loads the output register. One request
// is taken every cycle unless the output is stalled or the clear is running; the
// result register loads from the stage-one register when stage two advances. A
// write that lands at the same edge as the operand read is captured and used in
// place of the memory data; the flags live in a register that stage two updates.
// After reset a sweep clears all 16 registers, during which no request is accepted.
module thumb_add_adc_execute_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [4:0]  encoding,
	input  wire logic [15:0] instr_high,
	input  wire logic [15:0] instr_low,
	input  wire logic        in_it_block,
	input  wire logic [3:0]  reg_index,
	input  wire logic [31:0] write_value,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [3:0]  dest_reg,
	output      logic [31:0] data,
	output      logic        flag_n,
	output      logic        flag_z,
	output      logic        flag_c,
	output      logic        flag_v,
	output      logic        flags_updated
);
	import taae_pkg::*;

	logic [31:0] rf [16];
	dec_t        dec, dec_s1;
	logic [31:0] ra_s1, rb_s1;
	logic [3:0]  flags_q;
	logic        clr_q;
	logic [3:0]  clr_idx_q;
	logic        adv, acc;
	logic        wen;
	logic [3:0]  widx;
	logic [31:0] wdat;
	logic [31:0] a_op, b_rm, b_sh, b_op, sum;
	logic [32:0] wide;
	logic        cin, vout;
	logic [3:0]  nflags;
	logic        fa_q, fb_q;
	logic [31:0] fwd_q;

	taae_decode u_dec (
		.cmd(cmd), .encoding(encoding), .instr_high(instr_high),
		.instr_low(instr_low), .in_it_block(in_it_block),
		.reg_index(reg_index), .write_value(write_value), .dec(dec)
	);

	assign adv = !out_valid || !out_stall;
	assign in_stall = clr_q || !adv;
	assign acc = in_valid && !in_stall;

	// The memory read misses a write at the same edge; use the captured value.
	assign a_op = fa_q ? fwd_q : ra_s1;
	assign b_rm = fb_q ? fwd_q : rb_s1;

	logic [5:0] sh_r;
	assign sh_r = 6'd32 - {1'b0, dec_s1.sh_amt};
	always_comb begin
		case (dec_s1.sh_type)
			SH_LSL: b_sh = b_rm << dec_s1.sh_amt;
			SH_LSR: b_sh = (dec_s1.sh_amt == 5'd0) ? 32'd0 : b_rm >> dec_s1.sh_amt;
			SH_ASR: b_sh = (dec_s1.sh_amt == 5'd0) ? {32{b_rm[31]}}
				: 32'($signed(b_rm) >>> dec_s1.sh_amt);
			default: b_sh = (dec_s1.sh_amt == 5'd0) ? {flags_q[1], b_rm[31:1]}
				: (b_rm >> dec_s1.sh_amt) | (b_rm << sh_r);
		endcase
		if (!dec_s1.b_reg) b_op = dec_s1.b_imm;
		else if (dec_s1.b_shift) b_op = b_sh;
		else b_op = b_rm;
	end

	assign cin  = dec_s1.use_c & flags_q[1];
	assign wide = {1'b0, a_op} + {1'b0, b_op} + {32'd0, cin};
	assign sum  = wide[31:0];
	assign vout = ~(a_op[31] ^ b_op[31]) & (a_op[31] ^ sum[31]);
	assign nflags = {sum[31], sum == 32'd0, wide[32], vout};

	// Stage two advances only with the output register, so writeback is
	// gated by the same condition.
	always_comb begin
		wen  = clr_q || (dec_s1.valid && dec_s1.wr && adv);
		widx = clr_q ? clr_idx_q : dec_s1.dest;
		wdat = clr_q ? 32'd0 : (dec_s1.exec ? sum : dec_s1.wval);
	end

	always_ff @(posedge clk) begin
		if (wen) rf[widx] <= wdat;
		if (acc) begin
			ra_s1 <= rf[dec.a_idx];
			rb_s1 <= rf[dec.b_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_idx_q <= '0;
			dec_s1 <= '0;
			flags_q <= '0;
			out_valid <= 1'b0;
			fa_q <= 1'b0;
			fb_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 4'd1;
				if (clr_idx_q == 4'd15) clr_q <= 1'b0;
			end
			if (acc) begin
				dec_s1 <= dec;
				fa_q <= wen && widx == dec.a_idx;
				fb_q <= wen && widx == dec.b_idx;
			end else if (adv) begin
				dec_s1.valid <= 1'b0;
				fa_q <= 1'b0;
				fb_q <= 1'b0;
			end
			if (adv) begin
				out_valid <= dec_s1.valid;
				if (dec_s1.valid && dec_s1.setf) flags_q <= nflags;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) fwd_q <= wdat;
		if (adv && dec_s1.valid) begin
			dest_reg <= dec_s1.dest;
			data <= dec_s1.exec ? sum : (dec_s1.wr ? dec_s1.wval : (dec_s1.rd ? a_op : 32'd0));
			{flag_n, flag_z, flag_c, flag_v} <= dec_s1.setf ? nflags : flags_q;
			flags_updated <= dec_s1.setf;
		end
	end

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !acc) else $error("request accepted during clear");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data))
		else $error("stalled result changed");
	a_flags_only_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && dec_s1.valid && dec_s1.setf) |=> $stable(flags_q))
		else $error("flags changed without a setting instruction");
endmodule
`default_nettype wire

// File: tb/thumb_add_adc_execute_core_checker.sv
`default_nettype none
module thumb_add_adc_execute_core_checker (
	input  wire logic        clk,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [4:0]  encoding,
	input  wire logic [15:0] instr_high,
	input  wire logic [15:0] instr_low,
	input  wire logic        in_it_block,
	input  wire logic [3:0]  reg_index,
	input  wire logic [31:0] write_value,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [3:0]  dest_reg,
	input  wire logic [31:0] data,
	input  wire logic        flag_n,
	input  wire logic        flag_z,
	input  wire logic        flag_c,
	input  wire logic        flag_v,
	input  wire logic        flags_updated,
	output int               fail_count,
	output int               pending_count,
	output int               result_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import taae_pkg::*;

	typedef struct packed {
		logic [3:0]  dest;
		logic [31:0] value;
		logic [3:0]  nzcv;
		logic        updated;
	} alu_result_t;

	logic [31:0] regs [16];
	logic [3:0]  nzcv;
	alu_result_t expected_results [$];

	initial begin
		for (int i = 0; i < 16; i++) regs[i] = '0;
		nzcv = '0;
		fail_count = 0;
		result_count = 0;
	end

	assign pending_count = expected_results.size();

	function automatic logic [31:0] ror32(logic [31:0] v, logic [4:0] n);
		return (n == 0) ? v : ((v >> n) | (v << (6'd32 - n)));
	endfunction

	function automatic logic [31:0] modified_imm(logic [11:0] imm12);
		logic [7:0] b;
		b = imm12[7:0];
		if (imm12[11:10] == 2'b00) begin
			case (imm12[9:8])
				2'd0: return {24'd0, b};
				2'd1: return {8'd0, b, 8'd0, b};
				2'd2: return {b, 8'd0, b, 8'd0};
				default: return {b, b, b, b};
			endcase
		end
		return ror32({24'd0, 1'b1, imm12[6:0]}, imm12[11:7]);
	endfunction

	function automatic logic [31:0] shifted_operand(logic [31:0] v, logic [1:0] kind,
			logic [4:0] amt, logic cin);
		case (kind)
			SH_LSL: return v << amt;
			SH_LSR: return (amt == 0) ? 32'd0 : v >> amt;
			SH_ASR: return (amt == 0) ? {32{v[31]}} : 32'($signed(v) >>> amt);
			default: return (amt == 0) ? {cin, v[31:1]} : ror32(v, amt);
		endcase
	endfunction

	task automatic execute_request();
		alu_result_t res;
		logic [31:0] a, b, sp, sum;
		logic [32:0] wide;
		logic [3:0] d, dn, m;
		logic [11:0] imm12;
		logic [4:0] imm5;
		logic cin, setf, oldc;
		res = '0;
		a = '0; b = '0; cin = 1'b0; setf = 1'b0; d = '0;
		oldc = nzcv[1];
		sp = regs[SP_IDX];
		imm12 = {instr_high[10], instr_low[14:12], instr_low[7:0]};
		imm5 = {instr_low[14:12], instr_low[7:6]};
		if (cmd == CMD_WRITE) begin
			regs[reg_index] = write_value;
			res.dest = reg_index;
			res.value = write_value;
		end else if (cmd != CMD_EXEC) begin
			res.dest = reg_index;
			res.value = regs[reg_index];
		end else if (encoding <= ENC_ADD_SPR_T3) begin
			case (encoding)
				ENC_ADC_REG_T1: begin
					d = {1'b0, instr_low[2:0]}; a = regs[d];
					b = regs[{1'b0, instr_low[5:3]}]; cin = oldc; setf = !in_it_block;
				end
				ENC_ADD_IMM_T1: begin
					d = {1'b0, instr_low[2:0]}; a = regs[{1'b0, instr_low[5:3]}];
					b = {29'd0, instr_low[8:6]}; setf = !in_it_block;
				end
				ENC_ADD_IMM_T2: begin
					d = {1'b0, instr_low[10:8]}; a = regs[d];
					b = {24'd0, instr_low[7:0]}; setf = !in_it_block;
				end
				ENC_ADD_REG_T1: begin
					d = {1'b0, instr_low[2:0]}; a = regs[{1'b0, instr_low[5:3]}];
					b = regs[{1'b0, instr_low[8:6]}]; setf = !in_it_block;
				end
				ENC_ADD_REG_T2: begin
					dn = {instr_low[7], instr_low[2:0]};
					m = instr_low[6:3];
					d = (m != SP_IDX && dn == SP_IDX) ? SP_IDX : dn;
					a = (m == SP_IDX || dn == SP_IDX) ? sp : regs[dn];
					b = (m == SP_IDX) ? regs[dn] : regs[m];
				end
				ENC_ADD_SPI_T1: begin
					d = {1'b0, instr_low[10:8]}; a = sp; b = {22'd0, instr_low[7:0], 2'b00};
				end
				ENC_ADD_SPI_T2: begin
					d = SP_IDX; a = sp; b = {23'd0, instr_low[6:0], 2'b00};
				end
				ENC_ADD_SPR_T1: begin
					d = {instr_low[7], instr_low[2:0]}; a = sp; b = regs[d];
				end
				ENC_ADD_SPR_T2: begin
					d = SP_IDX; a = sp; b = regs[instr_low[6:3]];
				end
				ENC_ADC_IMM_T1: begin
					d = instr_low[11:8]; a = regs[instr_high[3:0]];
					b = modified_imm(imm12); cin = oldc; setf = instr_high[4];
				end
				ENC_ADC_REG_T2: begin
					d = instr_low[11:8]; a = regs[instr_high[3:0]];
					b = shifted_operand(regs[instr_low[3:0]], instr_low[5:4], imm5, oldc);
					cin = oldc; setf = instr_high[4];
				end
				ENC_ADD_IMM_T3, ENC_ADD_SPI_T3: begin
					d = instr_low[11:8];
					a = (encoding == ENC_ADD_SPI_T3) ? sp : regs[instr_high[3:0]];
					b = modified_imm(imm12); setf = instr_high[4];
				end
				ENC_ADD_IMM_T4, ENC_ADD_SPI_T4: begin
					d = instr_low[11:8];
					a = (encoding == ENC_ADD_SPI_T4) ? sp : regs[instr_high[3:0]];
					b = {20'd0, imm12};
				end
				default: begin
					d = instr_low[11:8];
					a = (encoding == ENC_ADD_SPR_T3) ? sp : regs[instr_high[3:0]];
					b = shifted_operand(regs[instr_low[3:0]], instr_low[5:4], imm5, oldc);
					setf = instr_high[4];
				end
			endcase
			wide = {1'b0, a} + {1'b0, b} + {32'd0, cin};
			sum = wide[31:0];
			regs[d] = sum;
			res.dest = d;
			res.value = sum;
			if (setf) begin
				nzcv = {sum[31], sum == 0, wide[32], ~(a[31] ^ b[31]) & (a[31] ^ sum[31])};
				res.updated = 1'b1;
			end
		end
		res.nzcv = nzcv;
		expected_results.push_back(res);
	endtask

	always @(posedge clk) begin
		alu_result_t want, got;
		if (in_valid && !in_stall)
			execute_request();
		if (out_valid && !out_stall) begin
			got = '{dest_reg, data, {flag_n, flag_z, flag_c, flag_v}, flags_updated};
			result_count++;
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result dest=%0d data=%h", dest_reg, data);
			end else begin
				want = expected_results.pop_front();
				if (want !== got) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected dest=%0d data=%h nzcv=%b upd=%b, got dest=%0d data=%h nzcv=%b upd=%b",
							want.dest, want.value, want.nzcv, want.updated,
							got.dest, got.value, got.nzcv, got.updated);
				end
			end
		end
	end
endmodule
`default_nettype wire

// File: tb/thumb_add_adc_execute_core_test.sv
`default_nettype none
module thumb_add_adc_execute_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import taae_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_READ;
	logic [4:0]  encoding = '0;
	logic [15:0] instr_high = '0;
	logic [15:0] instr_low = '0;
	logic        in_it_block = 1'b0;
	logic [3:0]  reg_index = '0;
	logic [31:0] write_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [3:0]  dest_reg;
	logic [31:0] data;
	logic        flag_n, flag_z, flag_c, flag_v, flags_updated;
	int          fail_count, pending_count, result_count;
	bit          hold_off = 1'b0;
	bit          stim_done = 1'b0;
	int          sent = 0;

	thumb_add_adc_execute_core i_dut (.*);
	thumb_add_adc_execute_core_checker i_checker (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("thumb_add_adc_execute_core verification failed");
		$finish;
	end

	// Offers one request and holds it until the block takes it.
	task automatic send_request(logic [1:0] c, logic [4:0] e, logic [15:0] hi,
			logic [15:0] lo, logic it, logic [3:0] idx, logic [31:0] wv);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c; encoding <= e; instr_high <= hi; instr_low <= lo;
		in_it_block <= it; reg_index <= idx; write_value <= wv;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic random_request();
		int pick;
		logic [1:0] c;
		logic [4:0] e;
		pick = $urandom_range(0, 99);
		c = pick < 12 ? CMD_WRITE : pick < 18 ? CMD_READ : pick < 20 ? CMD_ALT : CMD_EXEC;
		e = pick < 97 ? 5'($urandom_range(0, 16)) : 5'($urandom_range(17, 31));
		send_request(c, e, 16'($urandom), 16'($urandom), 1'($urandom),
			4'($urandom), $urandom_range(0, 3) == 0 ? {32{1'($urandom)}} ^ 32'($urandom_range(0, 2))
			: $urandom);
	endtask

	// Result side: random stalls, plus one long hold-off.
	initial begin
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
			end else begin
				wait_cycles = $urandom_range(0, 2) == 0 ? $urandom_range(0, 13) : 0;
				if (wait_cycles > 0) begin
					out_stall <= 1'b1;
					repeat (wait_cycles - 1) @(negedge clk);
				end else begin
					out_stall <= 1'b0;
				end
			end
		end
	end

	initial begin
		@(posedge arst_n);
		wait (sent == 600);
		hold_off = 1'b1;
		repeat (200) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// Directed part: register extremes, each encoding, the special cases.
		send_request(CMD_WRITE, '0, '0, '0, 1'b0, 4'd1, 32'hFFFF_FFFF);
		send_request(CMD_WRITE, '0, '0, '0, 1'b0, 4'd2, 32'h0000_0001);
		send_request(CMD_WRITE, '0, '0, '0, 1'b0, SP_IDX, 32'h7FFF_FFFC);
		send_request(CMD_WRITE, '0, '0, '0, 1'b0, 4'd15, 32'h8000_0000);
		send_request(CMD_EXEC, ENC_ADD_REG_T1, '0, 16'h0088, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADC_REG_T1, '0, 16'h000B, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_IMM_T1, '0, 16'h01D3, 1'b1, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_IMM_T2, '0, 16'h01FF, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_REG_T2, '0, 16'h00EA, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_REG_T2, '0, 16'h00BD, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_REG_T2, '0, 16'h0079, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_SPI_T1, '0, 16'h07FF, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_SPI_T2, '0, 16'h007F, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_SPR_T1, '0, 16'h0081, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_SPR_T2, '0, 16'h0078, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADC_IMM_T1, 16'h0411, 16'h7FFF, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADC_REG_T2, 16'h0011, 16'h0F31, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_IMM_T3, 16'h001D, 16'h23AB, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_IMM_T4, 16'h040D, 16'h7FFF, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_REG_T3, 16'h0012, 16'h7FE1, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_SPI_T3, 16'h0010, 16'h0F00, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_SPI_T4, 16'h0000, 16'h0501, 1'b0, '0, '0);
		send_request(CMD_EXEC, ENC_ADD_SPR_T3, 16'h0010, 16'h0F22, 1'b0, '0, '0);
		send_request(CMD_EXEC, 5'd31, 16'hFFFF, 16'hFFFF, 1'b1, '0, '0);
		send_request(CMD_ALT, '0, '0, '0, 1'b0, 4'd15, '0);
		repeat (1750) random_request();
		in_valid <= 1'b0;
		stim_done = 1'b1;
		wait (pending_count == 0);
		repeat (20) @(posedge clk);
		$display("Sent %0d requests over all seventeen encodings and the register commands,",
			sent);
		$display("and checked %0d results under random and long output stalls.", result_count);
		if (fail_count == 0)
			$display("thumb_add_adc_execute_core verification clean");
		else
			$display("thumb_add_adc_execute_core verification failed");
		$finish;
	end
endmodule
`default_nettype wire
